// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic form with explicit clock and active-low reset
`define MCRX_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// form on the block clock and reset
`define MCRX_ASSERT_CLK(lbl, prop, msg) \
    `MCRX_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ----- rtl/mcrx_pkg.sv -----
// ----------------------------------------------------------------------------
// mcrx_pkg
// shared widths, codes and types of the multicast chunk receive tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcrx_pkg;

    localparam int TEAM_SIZE    = 16;
    localparam int RANK_W       = 4;
    localparam int MAX_PPR      = 4096;
    localparam int HEADER_BYTES = 40;

    localparam int TAG_W      = 16;
    localparam int CHUNK_W    = 24;
    localparam int LEN_W      = 13;
    localparam int PPR_W      = 13;
    localparam int STRIDE_W   = 32;
    localparam int SLOTS_W    = 13;
    localparam int SLOT_W     = 12;
    localparam int TOTAL_W    = 16;
    localparam int CNT_W      = 13;
    localparam int OFFSET_W   = 40;
    localparam int STATUS_W   = 3;
    localparam int DIVIDEND_W = 16;
    localparam int WITHIN_W   = 12;

    localparam int BM_ROW_W   = 16;
    localparam int BM_BIT_W   = 4;
    localparam int BM_ADDR_W  = 12;
    localparam int BM_ROWS    = 4096;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STALE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LOOPBACK = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd4;

    localparam logic [2:0] REG_TASK_TAG    = 3'd0;
    localparam logic [2:0] REG_PPR         = 3'd1;
    localparam logic [2:0] REG_STRIDE      = 3'd2;
    localparam logic [2:0] REG_CHUNK_BYTES = 3'd3;
    localparam logic [2:0] REG_LB_FIRST    = 3'd4;
    localparam logic [2:0] REG_LB_LAST     = 3'd5;
    localparam logic [2:0] REG_RING_SLOTS  = 3'd6;
    localparam logic [2:0] REG_EXPECTED    = 3'd7;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [PPR_W-1:0]      divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [RANK_W-1:0]   quot;
        logic [WITHIN_W-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

// ----- rtl/mcrx_if.sv -----
// ----------------------------------------------------------------------------
// mcrx_if
// valid/ready channels for completions in and tracking results out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mcrx_in_if;
    logic                         valid;
    logic                         ready;
    logic [mcrx_pkg::TAG_W-1:0]   task_tag;
    logic [mcrx_pkg::CHUNK_W-1:0] chunk_number;
    logic [mcrx_pkg::LEN_W-1:0]   wire_length;

    modport source (output valid, task_tag, chunk_number, wire_length, input ready);
    modport sink   (input valid, task_tag, chunk_number, wire_length, output ready);
endinterface

interface mcrx_out_if;
    logic                          valid;
    logic                          ready;
    logic [mcrx_pkg::STATUS_W-1:0] status;
    logic [mcrx_pkg::RANK_W-1:0]   sender_rank;
    logic [mcrx_pkg::OFFSET_W-1:0] dest_offset;
    logic [mcrx_pkg::LEN_W-1:0]    payload_length;
    logic [mcrx_pkg::SLOT_W-1:0]   staging_slot;
    logic [mcrx_pkg::TOTAL_W-1:0]  remaining_chunks;
    logic                          all_received;

    modport source (output valid, status, sender_rank, dest_offset, payload_length,
                    staging_slot, remaining_chunks, all_received, input ready);
    modport sink   (input valid, status, sender_rank, dest_offset, payload_length,
                    staging_slot, remaining_chunks, all_received, output ready);
endinterface

`default_nettype wire

// ----- rtl/mcrx_div.sv -----
// ----------------------------------------------------------------------------
// mcrx_div
// rank divider: restoring division, two quotient bits per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcrx_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mcrx_pkg::t_div_req i_req,
    output mcrx_pkg::t_div_rsp      o_rsp
);

    logic                            r_busy;
    logic                            r_step;
    logic                            r_done;
    logic [mcrx_pkg::DIVIDEND_W-1:0] r_rem;
    logic [mcrx_pkg::RANK_W-1:0]     r_quot;
    logic [mcrx_pkg::PPR_W-1:0]      r_div;

    logic [mcrx_pkg::DIVIDEND_W-1:0] n_rem;
    logic [mcrx_pkg::RANK_W-1:0]     n_quot;

    always_comb begin
        logic [1:0]                      sh_hi;
        logic [1:0]                      sh_lo;
        logic [mcrx_pkg::DIVIDEND_W:0]   d_hi;
        logic [mcrx_pkg::DIVIDEND_W:0]   d_lo;
        logic [mcrx_pkg::DIVIDEND_W-1:0] rem_a;
        sh_hi  = {r_step, 1'b1};
        sh_lo  = {r_step, 1'b0};
        d_hi   = (mcrx_pkg::DIVIDEND_W+1)'(r_div) << sh_hi;
        d_lo   = (mcrx_pkg::DIVIDEND_W+1)'(r_div) << sh_lo;
        rem_a  = r_rem;
        n_quot = r_quot;
        if ({1'b0, rem_a} >= d_hi) begin
            rem_a         = rem_a - d_hi[mcrx_pkg::DIVIDEND_W-1:0];
            n_quot[sh_hi] = 1'b1;
        end
        n_rem = rem_a;
        if ({1'b0, rem_a} >= d_lo) begin
            n_rem         = rem_a - d_lo[mcrx_pkg::DIVIDEND_W-1:0];
            n_quot[sh_lo] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= 1'b1;
            end else if (r_busy) begin
                if (!r_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.dividend;
            r_quot <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem[mcrx_pkg::WITHIN_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/multicast_chunk_rx_tracker.sv -----
// Takes one multicast receive completion per word and returns one result word.
// A chunk that passes the length, task tag, loopback and rank checks goes
// through the rank divider (two quotient bits per cycle), the memory read of
// the rank counter and bitmap row as the divider finishes, and the write-back,
// which waits for a free output register, before the next word is accepted.
// A dropped chunk goes straight to write-back. A finished result waits in the
// output register while the next completion is taken. After reset the
// received bitmap (4096 rows of 16 bits) is cleared one row a cycle, during
// which no completion is accepted; register writes are taken throughout.
// ----------------------------------------------------------------------------
// multicast_chunk_rx_tracker
// multicast chunk receive tracking with apb register port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module multicast_chunk_rx_tracker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mcrx_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [mcrx_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [mcrx_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    mcrx_in_if.sink                                i_in,
    mcrx_out_if.source                             o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;

    // registers
    logic [mcrx_pkg::TAG_W-1:0]    r_task_tag;
    logic [mcrx_pkg::PPR_W-1:0]    r_ppr;
    logic [mcrx_pkg::STRIDE_W-1:0] r_stride;
    logic [mcrx_pkg::PPR_W-1:0]    r_chunk_bytes;
    logic [mcrx_pkg::CHUNK_W-1:0]  r_lb_first;
    logic [mcrx_pkg::CHUNK_W-1:0]  r_lb_last;
    logic [mcrx_pkg::SLOTS_W-1:0]  r_ring_slots;
    logic [mcrx_pkg::TOTAL_W-1:0]  r_expected;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic                          r_clr_busy;
    logic [mcrx_pkg::BM_ADDR_W-1:0] r_clr_addr;
    logic [mcrx_pkg::TOTAL_W-1:0]  r_total;
    logic [mcrx_pkg::SLOT_W-1:0]   r_tail;
    logic [mcrx_pkg::TEAM_SIZE-1:0] r_cnt_vld;

    logic [mcrx_pkg::STATUS_W-1:0] r_status;
    logic [mcrx_pkg::LEN_W-1:0]    r_payload;
    logic [mcrx_pkg::CHUNK_W-1:0]  r_chunk;
    logic [mcrx_pkg::RANK_W-1:0]   r_rank;
    logic [mcrx_pkg::STRIDE_W+mcrx_pkg::RANK_W-1:0] r_prod_a;
    logic [mcrx_pkg::PPR_W+mcrx_pkg::WITHIN_W-1:0]  r_prod_b;

    logic [mcrx_pkg::CNT_W-1:0]    cnt_mem [mcrx_pkg::TEAM_SIZE];
    logic [mcrx_pkg::BM_ROW_W-1:0] bm_mem  [mcrx_pkg::BM_ROWS];
    logic [mcrx_pkg::CNT_W-1:0]    r_cnt_rd;
    logic [mcrx_pkg::BM_ROW_W-1:0] r_bm_rd;

    logic                          r_out_valid;
    logic [mcrx_pkg::STATUS_W-1:0] r_o_status;
    logic [mcrx_pkg::RANK_W-1:0]   r_o_rank;
    logic [mcrx_pkg::OFFSET_W-1:0] r_o_offset;
    logic [mcrx_pkg::LEN_W-1:0]    r_o_payload;
    logic [mcrx_pkg::SLOT_W-1:0]   r_o_slot;
    logic [mcrx_pkg::TOTAL_W-1:0]  r_o_remaining;
    logic                          r_o_all;

    mcrx_pkg::t_div_req div_req;
    mcrx_pkg::t_div_rsp div_rsp;

    logic                          cfg_wr;
    logic [mcrx_pkg::PPR_W-1:0]    ppr_eff;
    logic [mcrx_pkg::SLOTS_W-1:0]  slots_eff;
    logic                          in_fire;
    logic [mcrx_pkg::STATUS_W-1:0] pre_status;
    logic [mcrx_pkg::LEN_W-1:0]    pre_payload;
    logic                          out_free;
    logic                          wb_fire;
    logic                          is_acc;
    logic                          rd_en;
    logic [mcrx_pkg::CNT_W-1:0]    cnt_nxt;
    logic [mcrx_pkg::TOTAL_W-1:0]  n_total;
    logic [mcrx_pkg::TOTAL_W-1:0]  remaining;
    logic [mcrx_pkg::SLOT_W-1:0]   n_tail;
    logic [mcrx_pkg::OFFSET_W-1:0] offset;
    logic                          bm_we;
    logic [mcrx_pkg::BM_ADDR_W-1:0] bm_waddr;
    logic [mcrx_pkg::BM_ROW_W-1:0] bm_wdata;

    // apb port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_tag    <= '0;
            r_ppr         <= mcrx_pkg::PPR_W'(1);
            r_stride      <= '0;
            r_chunk_bytes <= mcrx_pkg::PPR_W'(4096);
            r_lb_first    <= '1;
            r_lb_last     <= '1;
            r_ring_slots  <= mcrx_pkg::SLOTS_W'(4096);
            r_expected    <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                mcrx_pkg::REG_TASK_TAG:    r_task_tag    <= pwdata[mcrx_pkg::TAG_W-1:0];
                mcrx_pkg::REG_PPR:         r_ppr         <= pwdata[mcrx_pkg::PPR_W-1:0];
                mcrx_pkg::REG_STRIDE:      r_stride      <= pwdata;
                mcrx_pkg::REG_CHUNK_BYTES: r_chunk_bytes <= pwdata[mcrx_pkg::PPR_W-1:0];
                mcrx_pkg::REG_LB_FIRST:    r_lb_first    <= pwdata[mcrx_pkg::CHUNK_W-1:0];
                mcrx_pkg::REG_LB_LAST:     r_lb_last     <= pwdata[mcrx_pkg::CHUNK_W-1:0];
                mcrx_pkg::REG_RING_SLOTS:  r_ring_slots  <= pwdata[mcrx_pkg::SLOTS_W-1:0];
                mcrx_pkg::REG_EXPECTED:    r_expected    <= pwdata[mcrx_pkg::TOTAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            mcrx_pkg::REG_TASK_TAG:    prdata = mcrx_pkg::APB_DATA_W'(r_task_tag);
            mcrx_pkg::REG_PPR:         prdata = mcrx_pkg::APB_DATA_W'(r_ppr);
            mcrx_pkg::REG_STRIDE:      prdata = r_stride;
            mcrx_pkg::REG_CHUNK_BYTES: prdata = mcrx_pkg::APB_DATA_W'(r_chunk_bytes);
            mcrx_pkg::REG_LB_FIRST:    prdata = mcrx_pkg::APB_DATA_W'(r_lb_first);
            mcrx_pkg::REG_LB_LAST:     prdata = mcrx_pkg::APB_DATA_W'(r_lb_last);
            mcrx_pkg::REG_RING_SLOTS:  prdata = mcrx_pkg::APB_DATA_W'(r_ring_slots);
            mcrx_pkg::REG_EXPECTED:    prdata = mcrx_pkg::APB_DATA_W'(r_expected);
            default:                   prdata = '0;
        endcase
    end

    // clamped divisor and ring size
    always_comb begin
        if (r_ppr == '0) begin
            ppr_eff = mcrx_pkg::PPR_W'(1);
        end else if (r_ppr > mcrx_pkg::PPR_W'(mcrx_pkg::MAX_PPR)) begin
            ppr_eff = mcrx_pkg::PPR_W'(mcrx_pkg::MAX_PPR);
        end else begin
            ppr_eff = r_ppr;
        end
        if (r_ring_slots == '0) begin
            slots_eff = mcrx_pkg::SLOTS_W'(1);
        end else if (r_ring_slots > mcrx_pkg::SLOTS_W'(4096)) begin
            slots_eff = mcrx_pkg::SLOTS_W'(4096);
        end else begin
            slots_eff = r_ring_slots;
        end
    end

    // input checks
    assign i_in.ready = (r_state == S_IDLE) && !r_clr_busy;
    assign in_fire    = i_in.valid && i_in.ready;

    always_comb begin
        logic [mcrx_pkg::CHUNK_W-1:0] team_span;
        team_span   = mcrx_pkg::CHUNK_W'({ppr_eff, {mcrx_pkg::RANK_W{1'b0}}});
        pre_payload = '0;
        if (i_in.wire_length <= mcrx_pkg::LEN_W'(mcrx_pkg::HEADER_BYTES)) begin
            pre_status = mcrx_pkg::ST_SHORT;
        end else begin
            pre_payload = i_in.wire_length - mcrx_pkg::LEN_W'(mcrx_pkg::HEADER_BYTES);
            if (i_in.task_tag != r_task_tag) begin
                pre_status = mcrx_pkg::ST_STALE;
            end else if ((r_lb_first <= i_in.chunk_number) &&
                         (i_in.chunk_number <= r_lb_last)) begin
                pre_status = mcrx_pkg::ST_LOOPBACK;
            end else if (i_in.chunk_number >= team_span) begin
                pre_status = mcrx_pkg::ST_RANGE;
            end else begin
                pre_status = mcrx_pkg::ST_ACCEPTED;
            end
        end
    end

    assign div_req.start    = in_fire && (pre_status == mcrx_pkg::ST_ACCEPTED);
    assign div_req.dividend = i_in.chunk_number[mcrx_pkg::DIVIDEND_W-1:0];
    assign div_req.divisor  = ppr_eff;

    mcrx_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // write-back arithmetic
    assign out_free = !r_out_valid || o_out.ready;
    assign wb_fire  = (r_state == S_WB) && out_free;
    assign is_acc   = (r_status == mcrx_pkg::ST_ACCEPTED);
    assign rd_en    = (r_state == S_DIV) && div_rsp.done;

    always_comb begin
        logic [mcrx_pkg::CNT_W-1:0]   cnt_cur;
        logic [mcrx_pkg::SLOTS_W-1:0] tail_inc;
        cnt_cur = r_cnt_vld[r_rank] ? r_cnt_rd : '0;
        cnt_nxt = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;
        n_total = (is_acc && (r_total != '1)) ? r_total + 1'b1 : r_total;
        remaining = (r_expected > n_total) ? r_expected - n_total : '0;
        tail_inc = mcrx_pkg::SLOTS_W'(r_tail) + 1'b1;
        n_tail   = (tail_inc >= slots_eff) ? '0 : tail_inc[mcrx_pkg::SLOT_W-1:0];
        offset   = mcrx_pkg::OFFSET_W'(r_prod_a) + mcrx_pkg::OFFSET_W'(r_prod_b);
    end

    // state machine
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = (pre_status == mcrx_pkg::ST_ACCEPTED) ? S_DIV : S_WB;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_total     <= '0;
            r_tail      <= '0;
            r_cnt_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (wb_fire) begin
                r_out_valid <= 1'b1;
                r_total     <= n_total;
                r_tail      <= n_tail;
                if (is_acc) begin
                    r_cnt_vld[r_rank] <= 1'b1;
                end
            end
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_status  <= pre_status;
            r_payload <= pre_payload;
            r_chunk   <= i_in.chunk_number;
        end
        if (rd_en) begin
            r_rank   <= div_rsp.quot;
            r_prod_a <= (mcrx_pkg::STRIDE_W+mcrx_pkg::RANK_W)'(r_stride) *
                        (mcrx_pkg::STRIDE_W+mcrx_pkg::RANK_W)'(div_rsp.quot);
            r_prod_b <= (mcrx_pkg::PPR_W+mcrx_pkg::WITHIN_W)'(r_chunk_bytes) *
                        (mcrx_pkg::PPR_W+mcrx_pkg::WITHIN_W)'(div_rsp.rem);
        end
        if (wb_fire) begin
            r_o_status    <= r_status;
            r_o_rank      <= is_acc ? r_rank : '0;
            r_o_offset    <= is_acc ? offset : '0;
            r_o_payload   <= r_payload;
            r_o_slot      <= r_tail;
            r_o_remaining <= remaining;
            r_o_all       <= (remaining == '0);
        end
    end

    // rank counter memory
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_cnt_rd <= cnt_mem[div_rsp.quot];
        end
        if (wb_fire && is_acc) begin
            cnt_mem[r_rank] <= cnt_nxt;
        end
    end

    // received bitmap memory
    assign bm_we    = r_clr_busy || (wb_fire && is_acc);
    assign bm_waddr = r_clr_busy ? r_clr_addr :
                      r_chunk[mcrx_pkg::BM_BIT_W+mcrx_pkg::BM_ADDR_W-1:mcrx_pkg::BM_BIT_W];
    assign bm_wdata = r_clr_busy ? '0 :
                      (r_bm_rd | (mcrx_pkg::BM_ROW_W'(1) << r_chunk[mcrx_pkg::BM_BIT_W-1:0]));

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_bm_rd <= bm_mem[r_chunk[mcrx_pkg::BM_BIT_W+mcrx_pkg::BM_ADDR_W-1:
                                      mcrx_pkg::BM_BIT_W]];
        end
        if (bm_we) begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
    end

    // result word
    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_o_status;
    assign o_out.sender_rank      = r_o_rank;
    assign o_out.dest_offset      = r_o_offset;
    assign o_out.payload_length   = r_o_payload;
    assign o_out.staging_slot     = r_o_slot;
    assign o_out.remaining_chunks = r_o_remaining;
    assign o_out.all_received     = r_o_all;

    `MCRX_ASSERT_CLK(a_div_done_in_div, div_rsp.done |-> (r_state == S_DIV), "stray divider done")
    `MCRX_ASSERT_CLK(a_no_wb_in_clear, (r_state == S_WB) |-> !r_clr_busy, "wb during clear")
    `MCRX_ASSERT_CLK(a_out_held, (r_out_valid && !o_out.ready) |=> r_out_valid, "result word lost")

endmodule

`default_nettype wire
